// ===== hdl/cprpm_pkg.sv =====
// Shared types and constants for the capture period to rpm block.
package cprpm_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_DIVIDE,
        ST_FINISH
    } cprpm_state_t;

    localparam int SECONDS_PER_MINUTE = 60;
    localparam int DEGREES_PER_TURN   = 360;
    // floor(clock * 60 / 360) equals floor(clock / 6), as 360 is a multiple of 60.
    localparam int SCALE_DIVISOR      = DEGREES_PER_TURN / SECONDS_PER_MINUTE;

    localparam int CLOCK_WIDTH  = 32;
    localparam int DIV_WIDTH    = 32;
    localparam int DIV_STEPS    = DIV_WIDTH;
    localparam int COUNT_WIDTH  = $clog2(DIV_STEPS);
    localparam int SCALED_WIDTH = 30;
    localparam int RPM_WIDTH    = 16;
    localparam int PERIOD_OUT_WIDTH = 16;

    localparam logic [CLOCK_WIDTH-1:0]  CLOCK_HZ_RESET = 32'd72000000;
    localparam logic [SCALED_WIDTH-1:0] SCALED_RESET   =
        SCALED_WIDTH'(CLOCK_HZ_RESET / SCALE_DIVISOR);
    localparam logic [RPM_WIDTH-1:0]    RPM_MAX        = 16'hFFFF;

endpackage

// ===== hdl/capture_period_to_rpm.sv =====
// Tachometer: capture period and bit-serial rpm division.
//
// Usage
//   Input channel (in_valid/in_ready, capture_value): one timer capture per
//   motor edge. The period is the difference to the previous capture, modulo
//   2^CAPTURE_WIDTH; the previous capture starts at zero after reset.
//   Output channel (out_valid/out_ready): rpm, period_ticks, zero_period and
//   saturated, one result per request.
//   Configuration channel (cfg_valid/cfg_ready, clock_hz): the timer clock in
//   hertz. A write starts a serial divide by six of the clock, during which
//   no request is taken; the stored setting resets to 72 MHz.
// Sequence
//   A non-zero period goes through the restoring divider, one quotient bit
//   per cycle, and then to the final step, which writes the result; a new
//   request is taken only after the final step. A zero period skips the
//   divider and goes straight to the final step.
//   The output register lets the next request be taken while a result waits;
//   a stalled receiver holds the block in its final step until the output
//   register is free. Reset clears all control state and empties the output.
module capture_period_to_rpm
    import cprpm_pkg::*;
#(
    parameter int CAPTURE_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CLOCK_WIDTH-1:0]        clock_hz,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [CAPTURE_WIDTH-1:0]      capture_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [RPM_WIDTH-1:0]          rpm,
    output logic [PERIOD_OUT_WIDTH-1:0]   period_ticks,
    output logic                          zero_period,
    output logic                          saturated
);

    cprpm_state_t                 state_reg, state_next;
    logic [COUNT_WIDTH-1:0]       count_reg, count_next;
    logic [CAPTURE_WIDTH-1:0]     prev_capture_reg, prev_capture_next;
    logic [SCALED_WIDTH-1:0]      scaled_reg, scaled_next;
    logic                         out_valid_reg, out_valid_next;

    logic [CAPTURE_WIDTH-1:0]     divisor_reg, divisor_next;
    logic [CAPTURE_WIDTH-1:0]     rem_reg, rem_next;
    logic [DIV_WIDTH-1:0]         dvd_reg, dvd_next;
    logic                         zero_reg, zero_next;
    logic [RPM_WIDTH-1:0]         rpm_reg, rpm_next;
    logic [PERIOD_OUT_WIDTH-1:0]  period_out_reg, period_out_next;
    logic                         zero_out_reg, zero_out_next;
    logic                         sat_out_reg, sat_out_next;

    logic [CAPTURE_WIDTH-1:0]     period_in;
    logic [CAPTURE_WIDTH:0]       rem_shift;
    logic [CAPTURE_WIDTH:0]       rem_diff;
    logic                         quot_bit;
    logic [CAPTURE_WIDTH-1:0]     step_rem;
    logic [DIV_WIDTH-1:0]         step_dvd;
    logic                         last_step;
    logic [DIV_WIDTH-1:0]         period_ext;
    logic                         quot_over;

    assign period_in = capture_value - prev_capture_reg;

    // One restoring division step: bring down the next dividend bit and
    // subtract the divisor when it fits. The quotient shifts in from the right.
    assign rem_shift = {rem_reg, dvd_reg[DIV_WIDTH-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign quot_bit  = (rem_shift >= {1'b0, divisor_reg});
    assign step_rem  = quot_bit ? rem_diff[CAPTURE_WIDTH-1:0]
                                : rem_shift[CAPTURE_WIDTH-1:0];
    assign step_dvd  = {dvd_reg[DIV_WIDTH-2:0], quot_bit};
    assign last_step = (count_reg == COUNT_WIDTH'(DIV_STEPS - 1));

    assign period_ext = DIV_WIDTH'(divisor_reg);
    assign quot_over  = |dvd_reg[DIV_WIDTH-1:RPM_WIDTH];

    assign cfg_ready    = (state_reg == ST_IDLE);
    assign in_ready     = (state_reg == ST_IDLE) && !cfg_valid;
    assign out_valid    = out_valid_reg;
    assign rpm          = rpm_reg;
    assign period_ticks = period_out_reg;
    assign zero_period  = zero_out_reg;
    assign saturated    = sat_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            prev_capture_reg <= '0;
            scaled_reg       <= SCALED_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            prev_capture_reg <= prev_capture_next;
            scaled_reg       <= scaled_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg    <= divisor_next;
        rem_reg        <= rem_next;
        dvd_reg        <= dvd_next;
        zero_reg       <= zero_next;
        rpm_reg        <= rpm_next;
        period_out_reg <= period_out_next;
        zero_out_reg   <= zero_out_next;
        sat_out_reg    <= sat_out_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        prev_capture_next = prev_capture_reg;
        scaled_next       = scaled_reg;
        out_valid_next    = out_valid_reg;
        divisor_next      = divisor_reg;
        rem_next          = rem_reg;
        dvd_next          = dvd_reg;
        zero_next         = zero_reg;
        rpm_next          = rpm_reg;
        period_out_next   = period_out_reg;
        zero_out_next     = zero_out_reg;
        sat_out_next      = sat_out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                count_next = '0;
                rem_next   = '0;
                if (cfg_valid)
                begin
                    dvd_next     = DIV_WIDTH'(clock_hz);
                    divisor_next = CAPTURE_WIDTH'(SCALE_DIVISOR);
                    state_next   = ST_SCALE;
                end
                else if (in_valid)
                begin
                    prev_capture_next = capture_value;
                    divisor_next      = period_in;
                    dvd_next          = DIV_WIDTH'(scaled_reg);
                    zero_next         = (period_in == '0);
                    state_next        = (period_in == '0) ? ST_FINISH : ST_DIVIDE;
                end
            end
            ST_SCALE:
            begin
                rem_next   = step_rem;
                dvd_next   = step_dvd;
                count_next = count_reg + 1'b1;
                if (last_step)
                begin
                    scaled_next = step_dvd[SCALED_WIDTH-1:0];
                    state_next  = ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                rem_next   = step_rem;
                dvd_next   = step_dvd;
                count_next = count_reg + 1'b1;
                if (last_step)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    period_out_next = period_ext[PERIOD_OUT_WIDTH-1:0];
                    zero_out_next   = zero_reg;
                    sat_out_next    = !zero_reg && quot_over;
                    priority if (zero_reg)
                    begin
                        rpm_next = '0;
                    end
                    else if (quot_over)
                    begin
                        rpm_next = RPM_MAX;
                    end
                    else
                    begin
                        rpm_next = dvd_reg[RPM_WIDTH-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(zero_period && saturated))
        else $error("zero_period and saturated both set");

    a_zero_gives_no_rpm: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_period) |-> (rpm == '0 && period_ticks == '0))
        else $error("zero period result carries a speed or a period");

    a_sat_clamps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> (rpm == RPM_MAX))
        else $error("saturated result not clamped");

    a_nonzero_divides: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && capture_value != prev_capture_reg)
        |=> (state_reg == ST_DIVIDE && count_reg == '0))
        else $error("non-zero period did not start the divider");

    a_divide_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE && last_step) |=> (state_reg == ST_FINISH))
        else $error("divider overran its step count");
`endif

endmodule

// ===== tb/sv/tb_capture_period_to_rpm.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the capture period to rpm tachometer block.
module tb_capture_period_to_rpm;
    import cprpm_pkg::*;

    localparam int CAPTURE_BITS     = 16;
    localparam int PHASES           = 9;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int SETTLE_CYCLES    = 40;
    localparam int LONG_HOLD        = 300;
    localparam int CYCLE_LIMIT      = 500000;

    typedef struct packed {
        logic [RPM_WIDTH-1:0]        rpm;
        logic [PERIOD_OUT_WIDTH-1:0] period_ticks;
        logic                        zero_period;
        logic                        saturated;
    } speed_t;

    // Predicts the speed for each accepted capture and compares it with the block.
    class rpm_checker;
        logic [CLOCK_WIDTH-1:0]  timer_hz = CLOCK_HZ_RESET;
        logic [CAPTURE_BITS-1:0] last_capture = '0;
        speed_t expected_speeds[$];
        int errors = 0;
        int captures_seen = 0;
        int speeds_checked = 0;
        int zero_periods = 0;
        int clamped = 0;
        int clock_writes = 0;

        function void note_capture(input logic [CAPTURE_BITS-1:0] cap);
            logic [CAPTURE_BITS-1:0] span;
            logic [63:0]             scaled;
            logic [63:0]             quotient;
            speed_t                  want;
            span = cap - last_capture;
            last_capture = cap;
            want = '0;
            want.period_ticks = span[PERIOD_OUT_WIDTH-1:0];
            if (span == '0) begin
                want.zero_period = 1'b1;
                zero_periods++;
            end
            else begin
                scaled = (64'(timer_hz) * 64'(SECONDS_PER_MINUTE)) / 64'(DEGREES_PER_TURN);
                quotient = scaled / 64'(span);
                if (quotient > 64'(RPM_MAX)) begin
                    want.rpm = RPM_MAX;
                    want.saturated = 1'b1;
                    clamped++;
                end
                else begin
                    want.rpm = quotient[RPM_WIDTH-1:0];
                end
            end
            expected_speeds.push_back(want);
            captures_seen++;
        endfunction

        function void check_speed(input speed_t got);
            speed_t want;
            if (expected_speeds.size() == 0) begin
                errors++;
                $display("%0t: unexpected result rpm=%0d period=%0d zero=%0b sat=%0b",
                         $time, got.rpm, got.period_ticks, got.zero_period, got.saturated);
            end
            else begin
                want = expected_speeds.pop_front();
                speeds_checked++;
                if (got !== want) begin
                    errors++;
                    $display("%0t: mismatch expected rpm=%0d period=%0d zero=%0b sat=%0b",
                             $time, want.rpm, want.period_ticks, want.zero_period,
                             want.saturated);
                    $display("%0t:          actual   rpm=%0d period=%0d zero=%0b sat=%0b",
                             $time, got.rpm, got.period_ticks, got.zero_period,
                             got.saturated);
                end
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CLOCK_WIDTH-1:0]      clock_hz;
    logic                        in_valid;
    logic                        in_ready;
    logic [CAPTURE_BITS-1:0]     capture_value;
    logic                        out_valid;
    logic                        out_ready;
    logic [RPM_WIDTH-1:0]        rpm;
    logic [PERIOD_OUT_WIDTH-1:0] period_ticks;
    logic                        zero_period;
    logic                        saturated;

    rpm_checker              rpm_check = new;
    logic [CAPTURE_BITS-1:0] capture_now = '0;
    bit                      quiet = 1'b0;
    bit                      hold_output = 1'b0;
    int                      long_holds = 0;
    int                      cycle_count = 0;

    capture_period_to_rpm #(
        .CAPTURE_WIDTH(CAPTURE_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .clock_hz     (clock_hz),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .capture_value(capture_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .rpm          (rpm),
        .period_ticks (period_ticks),
        .zero_period  (zero_period),
        .saturated    (saturated)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin : monitor
        speed_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {rpm, period_ticks, zero_period, saturated};
                rpm_check.check_speed(got);
            end
            if (in_valid && in_ready)
                rpm_check.note_capture(capture_value);
            if (cfg_valid && cfg_ready)
            begin
                rpm_check.timer_hz = clock_hz;
                rpm_check.clock_writes++;
            end
        end
    end

    // Each pass sets out_ready once and then waits, so it never gets two updates in a step.
    initial
    begin : receiver
        int n;
        int k;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_output)
            begin
                hold_output = 1'b0;
                out_ready <= 1'b0;
                for (k = 0; k < LONG_HOLD; k++)
                    @(posedge clk);
                long_holds++;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 5);
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Valid is left high on return so that back-to-back requests need no second update.
    task automatic offer_capture(input logic [CAPTURE_BITS-1:0] cap);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        capture_now = cap;
        in_valid <= 1'b1;
        capture_value <= cap;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_clock_hz(input logic [CLOCK_WIDTH-1:0] hz);
        while (rpm_check.expected_speeds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        clock_hz <= hz;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Smallest period whose speed no longer clamps at the given timer clock.
    function automatic logic [CAPTURE_BITS-1:0] first_unclamped(input logic [CLOCK_WIDTH-1:0] hz);
        logic [63:0] scaled;
        scaled = (64'(hz) * 64'(SECONDS_PER_MINUTE)) / 64'(DEGREES_PER_TURN);
        return CAPTURE_BITS'(scaled / 64'd65536 + 64'd1);
    endfunction

    localparam logic [CAPTURE_BITS-1:0] EDGE_STEPS [12] = '{
        16'd0, 16'd1, 16'hFFFE, 16'd1, 16'd183, 16'd184,
        16'd0, 16'h8000, 16'h7FFF, 16'hFFFF, 16'd2, 16'd65535
    };

    initial
    begin : stimulus
        logic [CLOCK_WIDTH-1:0]  hz_plan [PHASES];
        logic [CAPTURE_BITS-1:0] edge_p;
        logic [CAPTURE_BITS-1:0] step;
        int p;
        int i;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        capture_value <= '0;
        cfg_valid <= 1'b0;
        clock_hz <= '0;
        hz_plan = '{CLOCK_HZ_RESET, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd393210,
                    32'd393216, 32'd0, 32'd6, CLOCK_HZ_RESET};
        hz_plan[6] = $urandom;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first request is measured from a previous capture of zero.
        foreach (EDGE_STEPS[i])
            offer_capture(capture_now + EDGE_STEPS[i]);
        offer_capture(16'hAAAA);
        offer_capture(16'h5555);

        for (p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                in_valid <= 1'b0;
                write_clock_hz(hz_plan[p]);
            end
            quiet = (p == PHASES - 1);
            if (p == 1)
                hold_output = 1'b1;
            edge_p = first_unclamped(hz_plan[p]);
            offer_capture(capture_now + 16'd1);
            offer_capture(capture_now + ((edge_p > 16'd1) ? edge_p - 16'd1 : 16'd1));
            offer_capture(capture_now + edge_p);
            offer_capture(capture_now + edge_p + 16'd1);
            offer_capture(capture_now);
            offer_capture(capture_now + 16'hFFFF);
            for (i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                case ($urandom_range(0, 9))
                    0: step = '0;
                    1: step = CAPTURE_BITS'($urandom_range(1, 8));
                    2: step = edge_p + CAPTURE_BITS'($urandom_range(0, 4)) - 16'd2;
                    3: step = CAPTURE_BITS'($urandom) - capture_now;
                    default: step = CAPTURE_BITS'($urandom_range(1, 65535));
                endcase
                offer_capture(capture_now + step);
            end
        end
        in_valid <= 1'b0;

        while (rpm_check.expected_speeds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d captures over %0d timer clock settings (%0d register writes).",
                 rpm_check.captures_seen, PHASES, rpm_check.clock_writes);
        $display("Compared %0d results: %0d zero periods, %0d clamped, %0d long output stalls.",
                 rpm_check.speeds_checked, rpm_check.zero_periods, rpm_check.clamped,
                 long_holds);
        if (rpm_check.errors == 0 && rpm_check.expected_speeds.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d errors, %0d results missing.", rpm_check.errors,
                     rpm_check.expected_speeds.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
